/* sv/tpdvm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdvm_pkg
// Shared types and constants of the two-phase dosing volume monitor.
// ----------------------------------------------------------------------------
package tpdvm_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_JUICE_TARGET = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_WATER_TARGET = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_JUICE_GAIN   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_WATER_GAIN   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_AREA         = 3'd4;

	localparam logic [1:0] ACT_SAMPLE      = 2'd0;
	localparam logic [1:0] ACT_START_JUICE = 2'd1;
	localparam logic [1:0] ACT_START_WATER = 2'd2;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_JUICE = 2'd1;
	localparam logic [1:0] PH_WATER = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// ceil(2^20 / 10) and ceil(2^21 / 5): exact over the operand ranges used
	localparam logic signed [19:0] RECIP10 = 20'sd104858;
	localparam logic signed [19:0] RECIP5  = 20'sd419431;

	// saturation bounds of the pre-divided volume, 5 * 2^15
	localparam logic signed [24:0] M_HI = 25'sd163839;
	localparam logic signed [24:0] M_LO = -25'sd163840;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRIFT,
		ST_AREA,
		ST_DIV,
		ST_THR,
		ST_FIN
	} st_t;

endpackage

/* sv/two_phase_dosing_volume_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_dosing_volume_monitor
// Tracks baseline and filtered volume of a juice phase and a water phase,
// advancing the phase on threshold; one shared 20x20 multiplier, sequenced.
// ----------------------------------------------------------------------------
// Sequence: a sample in the juice or water phase passes the drift, area,
// divide and threshold steps on the one multiplier, then the finish step;
// start items and ignored samples go straight to the finish step, which
// waits while the result is stalled. No new item is taken until idle again.
// Reset: asynchronous for the sequencer, settings and phase state: phase idle,
// volumes and baselines zero, no result pending; data registers are not reset.
module two_phase_dosing_volume_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tpdvm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tpdvm_pkg::CfgDataW-1:0] cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [1:0]                     action,
	input  logic [15:0]                    distance_mm,
	input  logic                           pump_on,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [1:0]                     phase,
	output logic signed [15:0]             volume_ml,
	output logic [15:0]                    baseline_mm,
	output logic                           advanced
);
	import tpdvm_pkg::*;

	st_t st_q, st_nxt;

	logic [7:0]  juice_target_q, water_target_q;
	logic [15:0] juice_gain_q, water_gain_q, area_q;

	logic [1:0]         phase_q;
	logic [15:0]        juice_base_q, water_base_q;
	logic signed [15:0] juice_vol_q, water_vol_q;

	logic [1:0]  act_q;
	logic [15:0] dist_q;
	logic        pump_q;
	logic signed [39:0] prod_q;
	logic        sat_hi_q, sat_lo_q;

	logic        res_valid_q;
	logic [1:0]  res_phase_q;
	logic signed [15:0] res_vol_q;
	logic [15:0] res_base_q;
	logic        res_adv_q;

	logic signed [19:0] mul_a, mul_b;
	logic signed [39:0] prod;
	logic en_base, en_vol, fin_go;

	logic               accept;
	logic               tracking;
	logic [15:0]        cur_base;
	logic signed [15:0] cur_vol;
	logic               below;
	logic [16:0]        diff5;
	logic [15:0]        base_new;
	logic signed [16:0] hgt;
	logic signed [33:0] prod_ext, vol_ext, vol_sum;
	logic signed [24:0] m_val, m_off;
	logic               sat_hi, sat_lo;
	logic [15:0]        quo5;
	logic signed [15:0] vol_new;
	logic signed [24:0] vol_scaled, thr_val;
	logic               trk_q_item, adv;
	logic [1:0]         phase_nxt;
	logic [15:0]        out_base;
	logic signed [15:0] out_vol;

	assign accept = sample_valid && !sample_stall;
	assign sample_stall = (st_q != ST_IDLE);
	assign tracking = (phase_q == PH_JUICE) || (phase_q == PH_WATER);

	assign cur_base = (phase_q == PH_JUICE) ? juice_base_q : water_base_q;
	assign cur_vol  = (phase_q == PH_JUICE) ? juice_vol_q : water_vol_q;

	// baseline drift
	assign below    = dist_q < cur_base;
	assign diff5    = {1'b0, cur_base} - {1'b0, dist_q} + 17'd5;
	assign base_new = cur_base - {3'b000, prod_q[32:20]};
	assign hgt      = signed'({1'b0, dist_q}) - signed'({1'b0, base_new});

	// volume filter: n = area * h + 2304 * v + 1280, then /512 and /5
	assign prod_ext = signed'({prod_q[32], prod_q[32:0]});
	assign vol_ext  = {{18{cur_vol[15]}}, cur_vol};
	assign vol_sum  = prod_ext + (vol_ext <<< 11) + (vol_ext <<< 8) + 34'sd1280;
	assign m_val    = vol_sum[33:9];
	assign sat_hi   = m_val > M_HI;
	assign sat_lo   = m_val < M_LO;
	assign m_off    = m_val - M_LO;
	assign quo5     = prod_q[36:21];
	always_comb begin
		priority if (sat_hi_q) begin
			vol_new = 16'sh7FFF;
		end else if (sat_lo_q) begin
			vol_new = 16'sh8000;
		end else begin
			vol_new = signed'({~quo5[15], quo5[14:0]});
		end
	end

	// threshold
	assign vol_scaled = {cur_vol[15], cur_vol, 8'h00};
	assign thr_val    = signed'({1'b0, prod_q[23:0]});
	assign trk_q_item = (act_q == ACT_SAMPLE) && tracking;
	assign adv        = trk_q_item && pump_q && (vol_scaled >= thr_val);

	always_comb begin
		priority if (act_q == ACT_START_JUICE) begin
			phase_nxt = PH_JUICE;
		end else if (act_q == ACT_START_WATER) begin
			phase_nxt = PH_WATER;
		end else if (adv) begin
			phase_nxt = phase_q + 2'd1;
		end else begin
			phase_nxt = phase_q;
		end
	end

	always_comb begin
		priority if (act_q == ACT_START_JUICE || act_q == ACT_START_WATER) begin
			out_base = dist_q;
			out_vol  = '0;
		end else if (phase_nxt == PH_IDLE) begin
			out_base = '0;
			out_vol  = '0;
		end else if (phase_nxt == PH_JUICE) begin
			out_base = juice_base_q;
			out_vol  = juice_vol_q;
		end else begin
			out_base = water_base_q;
			out_vol  = water_vol_q;
		end
	end

	// sequencer: next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_SAMPLE && tracking)
						st_nxt = ST_DRIFT;
					else
						st_nxt = ST_FIN;
				end
			end
			ST_DRIFT: st_nxt = ST_AREA;
			ST_AREA:  st_nxt = ST_DIV;
			ST_DIV:   st_nxt = ST_THR;
			ST_THR:   st_nxt = ST_FIN;
			ST_FIN: begin
				if (!(res_valid_q && result_stall))
					st_nxt = ST_IDLE;
			end
			default:  st_nxt = ST_IDLE;
		endcase
	end

	// sequencer: multiplier operands and enables
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		en_base = 1'b0;
		en_vol  = 1'b0;
		fin_go  = 1'b0;
		unique case (st_q)
			ST_IDLE: ;
			ST_DRIFT: begin
				mul_a = below ? signed'({3'b000, diff5}) : '0;
				mul_b = RECIP10;
			end
			ST_AREA: begin
				mul_a   = signed'({4'h0, area_q});
				mul_b   = {{3{hgt[16]}}, hgt};
				en_base = 1'b1;
			end
			ST_DIV: begin
				mul_a = signed'({1'b0, m_off[18:0]});
				mul_b = RECIP5;
			end
			ST_THR: begin
				mul_a  = (phase_q == PH_JUICE) ? signed'({12'h000, juice_target_q})
				                               : signed'({12'h000, water_target_q});
				mul_b  = (phase_q == PH_JUICE) ? signed'({4'h0, juice_gain_q})
				                               : signed'({4'h0, water_gain_q});
				en_vol = 1'b1;
			end
			ST_FIN: fin_go = !(res_valid_q && result_stall);
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			juice_target_q <= 8'd40;
			water_target_q <= 8'd150;
			juice_gain_q   <= 16'd4096;
			water_gain_q   <= 16'd4874;
			area_q         <= 16'd0;
			phase_q        <= PH_IDLE;
			juice_base_q   <= '0;
			water_base_q   <= '0;
			juice_vol_q    <= '0;
			water_vol_q    <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_JUICE_TARGET: juice_target_q <= cfg_data[7:0];
					CFG_WATER_TARGET: water_target_q <= cfg_data[7:0];
					CFG_JUICE_GAIN:   juice_gain_q   <= cfg_data;
					CFG_WATER_GAIN:   water_gain_q   <= cfg_data;
					CFG_AREA:         area_q         <= cfg_data;
					default: ;
				endcase
			end
			if (en_base) begin
				if (phase_q == PH_JUICE)
					juice_base_q <= base_new;
				else
					water_base_q <= base_new;
			end
			if (en_vol) begin
				if (phase_q == PH_JUICE)
					juice_vol_q <= vol_new;
				else
					water_vol_q <= vol_new;
			end
			if (fin_go) begin
				phase_q <= phase_nxt;
				if (act_q == ACT_START_JUICE) begin
					juice_base_q <= dist_q;
					juice_vol_q  <= '0;
				end else if (act_q == ACT_START_WATER) begin
					water_base_q <= dist_q;
					water_vol_q  <= '0;
				end
			end
			if (fin_go)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			dist_q <= distance_mm;
			pump_q <= pump_on;
		end
		// threshold product is held while the finish step waits
		if (st_q != ST_FIN)
			prod_q <= prod;
		if (st_q == ST_DIV) begin
			sat_hi_q <= sat_hi;
			sat_lo_q <= sat_lo;
		end
		if (fin_go) begin
			res_phase_q <= phase_nxt;
			res_vol_q   <= out_vol;
			res_base_q  <= out_base;
			res_adv_q   <= adv;
		end
	end

	assign result_valid = res_valid_q;
	assign phase        = res_phase_q;
	assign volume_ml    = res_vol_q;
	assign baseline_mm  = res_base_q;
	assign advanced     = res_adv_q;

	a_rise_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(st_q == ST_FIN))
		else $error("result without finish step");

	a_adv_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && advanced |-> (phase == PH_WATER || phase == PH_DONE))
		else $error("advance into invalid phase");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && phase == PH_IDLE |-> volume_ml == 16'sd0 && baseline_mm == 16'd0)
		else $error("idle result not zero");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> st_q != ST_IDLE)
		else $error("accepted transaction not started");

endmodule

/* tb/two_phase_dosing_volume_monitor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_dosing_volume_monitor_tb
// Feeds juice/water dosing runs, stray items and register changes through the
// volume monitor under varied backpressure. Every reading is checked against
// an in-bench model of baseline drift, volume filter and phase advance.
// ----------------------------------------------------------------------------
module two_phase_dosing_volume_monitor_tb;
	import tpdvm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [CfgIdxW-1:0] CFG_SPARE = CFG_AREA + 3'd1;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [1:0]  act;
		logic [15:0] lvl;
		logic        pump;
	} dose_item_t;

	typedef struct packed {
		logic [1:0]         ph;
		logic signed [15:0] vol;
		logic [15:0]        base;
		logic               adv;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [1:0] action = ACT_SAMPLE;
	logic [15:0] distance_mm = '0;
	logic pump_on = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [1:0] phase;
	logic signed [15:0] volume_ml;
	logic [15:0] baseline_mm;
	logic advanced;

	// model state and register copies
	logic [7:0]         cur_juice_tgt = 8'd40;
	logic [7:0]         cur_water_tgt = 8'd150;
	logic [15:0]        cur_juice_gain = 16'd4096;
	logic [15:0]        cur_water_gain = 16'd4874;
	logic [15:0]        cur_area = 16'd0;
	logic [1:0]         cur_phase = PH_IDLE;
	logic [15:0]        cur_juice_base = '0;
	logic [15:0]        cur_water_base = '0;
	logic signed [15:0] cur_juice_vol = '0;
	logic signed [15:0] cur_water_vol = '0;

	dose_item_t dose_items[$];
	reading_t   expected_readings[$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_left = 0;
	bit item_taken = 1'b0;
	int mismatches = 0;
	int cycle_count = 0;

	two_phase_dosing_volume_monitor u_top (.*);

	always #5 clk = ~clk;

	task automatic filter_level(inout logic [15:0] base, inout logic signed [15:0] vol,
			input logic [7:0] tgt, input logic [15:0] gain, input logic [15:0] lvl,
			input logic pump, output logic hit);
		longint b, d, v, a, n, q;
		b = base;
		d = lvl;
		v = vol;
		a = cur_area;
		if (d < b)
			b = b - (b - d + 5) / 10;
		n = a * (d - b) + v * 2304 + 1280;
		q = n / 2560;
		if (n % 2560 != 0 && n < 0)
			q = q - 1;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		base = b[15:0];
		vol = q[15:0];
		hit = pump && (q * 256 >= longint'(tgt) * longint'(gain));
	endtask

	task automatic predict_reading(input dose_item_t it, output reading_t r);
		logic hit;
		hit = 1'b0;
		case (it.act)
			ACT_START_JUICE: begin
				cur_juice_base = it.lvl;
				cur_juice_vol = '0;
				cur_phase = PH_JUICE;
			end
			ACT_START_WATER: begin
				cur_water_base = it.lvl;
				cur_water_vol = '0;
				cur_phase = PH_WATER;
			end
			ACT_SAMPLE: begin
				if (cur_phase == PH_JUICE) begin
					filter_level(cur_juice_base, cur_juice_vol, cur_juice_tgt, cur_juice_gain,
						it.lvl, it.pump, hit);
					if (hit)
						cur_phase = PH_WATER;
				end else if (cur_phase == PH_WATER) begin
					filter_level(cur_water_base, cur_water_vol, cur_water_tgt, cur_water_gain,
						it.lvl, it.pump, hit);
					if (hit)
						cur_phase = PH_DONE;
				end
			end
			default: ;
		endcase
		r.ph = cur_phase;
		r.adv = hit;
		r.vol = '0;
		r.base = '0;
		if (cur_phase == PH_JUICE) begin
			r.vol = cur_juice_vol;
			r.base = cur_juice_base;
		end else if (cur_phase != PH_IDLE) begin
			r.vol = cur_water_vol;
			r.base = cur_water_base;
		end
	endtask

	// sender: new transaction only after the previous one was taken
	always @(negedge clk) begin
		if (sample_valid && !item_taken) begin
		end else if (dose_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
			sample_valid <= 1'b1;
			action <= dose_items[0].act;
			distance_mm <= dose_items[0].lvl;
			pump_on <= dose_items[0].pump;
		end else begin
			sample_valid <= 1'b0;
		end
	end

	// receiver: long hold counted down here, else random stalls
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			result_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reading: phase %0d volume %0d baseline %0d adv %0b",
							phase, volume_ml, baseline_mm, advanced);
				end else begin
					want = expected_readings.pop_front();
					if (phase !== want.ph || volume_ml !== want.vol ||
							baseline_mm !== want.base || advanced !== want.adv) begin
						mismatches++;
						if (mismatches <= 10)
							$display("reading mismatch: exp ph %0d vol %0d base %0d adv %0b, %s %0d %0d %0d %0b",
								want.ph, want.vol, want.base, want.adv, "got",
								phase, volume_ml, baseline_mm, advanced);
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				predict_reading('{action, distance_mm, pump_on}, want);
				expected_readings.push_back(want);
				void'(dose_items.pop_front());
			end
			item_taken = sample_valid && !sample_stall;
			if (cfg_we) begin
				case (cfg_index)
					CFG_JUICE_TARGET: cur_juice_tgt = cfg_data[7:0];
					CFG_WATER_TARGET: cur_water_tgt = cfg_data[7:0];
					CFG_JUICE_GAIN:   cur_juice_gain = cfg_data;
					CFG_WATER_GAIN:   cur_water_gain = cfg_data;
					CFG_AREA:         cur_area = cfg_data;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] a, input logic [15:0] l, input logic p);
		dose_items.push_back('{a, l, p});
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic end_writes;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained;
		while (dose_items.size() != 0 || expected_readings.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_settings(input bit extreme);
		logic [15:0] v[5];
		for (int i = 0; i < 5; i++) begin
			if (extreme) begin
				case ($urandom_range(2))
					0: v[i] = '0;
					1: v[i] = '1;
					default: v[i] = 16'($urandom);
				endcase
			end else begin
				case (i)
					0: v[i] = 16'($urandom_range(1, 80));
					1: v[i] = 16'($urandom_range(1, 160));
					4: v[i] = 16'($urandom_range(64, 1024));
					default: v[i] = 16'($urandom_range(2048, 8192));
				endcase
			end
		end
		// junk in the unused upper byte of the 8-bit targets
		v[0][15:8] = 8'($urandom);
		v[1][15:8] = 8'($urandom);
		write_reg(CFG_JUICE_TARGET, v[0]);
		write_reg(CFG_WATER_TARGET, v[1]);
		write_reg(CFG_JUICE_GAIN, v[2]);
		write_reg(CFG_WATER_GAIN, v[3]);
		write_reg(CFG_AREA, v[4]);
		write_reg(CFG_SPARE + 3'($urandom_range(2)), 16'($urandom));
		end_writes();
	endtask

	// start juice, fill, start water, fill
	task automatic queue_dose_run(output int n);
		int lvl;
		int k;
		n = 0;
		for (int p = 0; p < 2; p++) begin
			lvl = $urandom_range(40000);
			push_item(p == 0 ? ACT_START_JUICE : ACT_START_WATER, lvl[15:0],
				1'($urandom_range(1)));
			k = $urandom_range(4, 40);
			repeat (k) begin
				if ($urandom_range(9) < 8)
					lvl = lvl + int'($urandom_range(120));
				else
					lvl = lvl - int'($urandom_range(60));
				if (lvl < 0)
					lvl = 0;
				if (lvl > 65535)
					lvl = 65535;
				push_item(ACT_SAMPLE, lvl[15:0], $urandom_range(9) != 0);
			end
			n += k + 1;
		end
	endtask

	task automatic run_phase(input int tx, input int rx, input bit extreme, input int count);
		int queued;
		int n;
		load_settings(extreme);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(99) < 80) begin
				queue_dose_run(n);
				queued += n;
			end else begin
				push_item(2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)));
				queued++;
			end
		end
		wait_drained();
	endtask

	initial begin
		int n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings: area zero
		push_item(ACT_SAMPLE, 16'h1234, 1'b1);
		push_item(ACT_UNUSED, 16'hFFFF, 1'b1);
		push_item(ACT_START_JUICE, 16'h0000, 1'b0);
		push_item(ACT_SAMPLE, 16'hFFFF, 1'b1);
		push_item(ACT_SAMPLE, 16'h0000, 1'b0);
		push_item(ACT_UNUSED, 16'h5555, 1'b0);
		push_item(ACT_START_WATER, 16'hFFFF, 1'b1);
		push_item(ACT_SAMPLE, 16'h0000, 1'b1);
		push_item(ACT_START_JUICE, 16'hAAAA, 1'b1);
		wait_drained();

		// extremes: saturation both ways, zero water threshold
		write_reg(CFG_JUICE_TARGET, 16'h00FF);
		write_reg(CFG_WATER_TARGET, 16'hFF00);
		write_reg(CFG_JUICE_GAIN, 16'hFFFF);
		write_reg(CFG_WATER_GAIN, 16'h0000);
		write_reg(CFG_AREA, 16'hFFFF);
		write_reg(CFG_SPARE + 3'd2, 16'h0000);
		end_writes();
		push_item(ACT_START_JUICE, 16'h0000, 1'b0);
		push_item(ACT_SAMPLE, 16'hFFFF, 1'b1);
		push_item(ACT_START_JUICE, 16'hFFFF, 1'b0);
		push_item(ACT_SAMPLE, 16'h0000, 1'b1);
		push_item(ACT_START_WATER, 16'h0100, 1'b0);
		push_item(ACT_SAMPLE, 16'h0100, 1'b0);
		push_item(ACT_SAMPLE, 16'h0100, 1'b1);
		push_item(ACT_SAMPLE, 16'h0000, 1'b1);
		push_item(ACT_START_WATER, 16'h0000, 1'b1);
		wait_drained();

		// juice advances on its first sample, then water right after
		write_reg(CFG_JUICE_GAIN, 16'h0000);
		end_writes();
		push_item(ACT_START_JUICE, 16'h2000, 1'b1);
		push_item(ACT_SAMPLE, 16'h2000, 1'b1);
		push_item(ACT_SAMPLE, 16'h2000, 1'b1);
		wait_drained();

		// long receiver hold while the sender keeps offering
		load_settings(1'b0);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_left = 300;
		queue_dose_run(n);
		while (rx_hold_left > 0)
			@(posedge clk);
		wait_drained();

		run_phase(0, 0, 1'b0, 100);
		run_phase(0, 0, 1'b1, 80);
		run_phase(77, 0, 1'b0, 100);
		run_phase(0, 77, 1'b0, 100);
		run_phase(11, 11, 1'b0, 100);
		run_phase(77, 0, 1'b1, 80);
		run_phase(0, 77, 1'b1, 80);
		run_phase(11, 11, 1'b0, 100);
		run_phase(0, 0, 1'b0, 60);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
